@@ hw/rtl/fba_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fba_pkg
// Shared types, constants and helpers of the FAT block allocator.
// ----------------------------------------------------------------------------
package fba_pkg;

	localparam int MAP_DEPTH = 4096;
	localparam int DATA_W    = 16;
	localparam int COUNT_W   = 13;
	localparam int CFG_IDX_W = 3;
	localparam int ADDR_W    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
	localparam int STEP_W    = $clog2(MAP_DEPTH + 1);
	localparam int CNT_W     = (STEP_W > COUNT_W) ? STEP_W : COUNT_W;
	localparam int COUNT_MAX = (1 << COUNT_W) - 1;

	localparam logic [DATA_W:0]   DEPTH_LIM = (DATA_W + 1)'(MAP_DEPTH);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_DEPTH - 1);

	typedef enum logic [1:0] {
		K_ALLOC = 2'd0,
		K_FREE  = 2'd1,
		K_READ  = 2'd2,
		K_WRITE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2,
		ST_LONG  = 2'd3
	} st_code_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		R_FIRST = 3'd0,
		R_LAST  = 3'd1,
		R_COUNT = 3'd2,
		R_FLOOR = 3'd3,
		R_FREEM = 3'd4,
		R_LASTM = 3'd5,
		R_RESVM = 3'd6
	} cfg_reg_t;

	typedef enum logic [2:0] {
		AS_RIGHT,
		AS_LEFT,
		AS_CUR,
		AS_IDX,
		AS_CLR
	} addr_sel_t;

	typedef enum logic [1:0] {
		WD_LAST,
		WD_FREE,
		WD_VAL,
		WD_ZERO
	} wd_sel_t;

	typedef enum logic [1:0] {
		BS_ZERO,
		BS_RIGHT,
		BS_LEFT,
		BS_RDATA
	} blk_sel_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_A_HEAD,
		S_A_R,
		S_A_RCMP,
		S_A_L,
		S_A_LCMP,
		S_F_HEAD,
		S_F_RD,
		S_RD_CHK,
		S_RD_WAIT,
		S_WR_CHK,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic      in_ready;
		logic      rd_en;
		addr_sel_t rd_sel;
		logic      wr_en;
		addr_sel_t wr_sel;
		wd_sel_t   wd_sel;
		logic      right_inc;
		logic      left_dec;
		logic      cur_step;
		logic      res_ld;
		blk_sel_t  res_blk;
		st_code_t  res_st;
		logic      out_load;
		logic      clr_inc;
	} cmd_t;

	typedef struct packed {
		logic  in_valid;
		kind_t in_kind;
		logic  right_ok;
		logic  left_ok;
		logic  right_in;
		logic  left_in;
		logic  rdata_free;
		logic  cur_mark;
		logic  cur_in;
		logic  step_lim;
		logic  idx_in;
		logic  clr_last;
		logic  out_free;
	} dp_stat_t;

	function automatic logic in_tbl(input logic [DATA_W-1:0] a);
		return {1'b0, a} < DEPTH_LIM;
	endfunction

	function automatic logic [ADDR_W-1:0] to_addr(input logic [DATA_W-1:0] a);
		return a[ADDR_W-1:0];
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/fba_ifs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fba_ifs
// Request and response channels of the FAT block allocator.
// ----------------------------------------------------------------------------
interface fba_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] block_index;
	logic [15:0] entry_value;

	modport source(output valid, kind, block_index, entry_value, input ready);
	modport sink(input valid, kind, block_index, entry_value, output ready);
endinterface

interface fba_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] result_block;
	logic [1:0]  status;
	logic [12:0] freed_count;

	modport source(output valid, result_block, status, freed_count, input ready);
	modport sink(input valid, result_block, status, freed_count, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/fba_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fba_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fba_ram #(
	parameter int W     = 16,
	parameter int DEPTH = 4096
) (
	input  wire                                   clk,
	input  wire                                   we,
	input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire  [W-1:0]                          wdata,
	input  wire                                   re,
	input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [W-1:0]                          rdata
);

	logic [W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/fba_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fba_dpath
// Datapath: configuration registers, search pointers, chain walker, link
// table and the output register.
// ----------------------------------------------------------------------------
module fba_dpath (
	input  wire                            clk,
	input  wire                            arst_n,
	fba_req_if.sink                        req,
	fba_rsp_if.source                      rsp,
	input  wire                            cfg_we,
	input  wire  [fba_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire  [fba_pkg::DATA_W-1:0]     cfg_wdata,
	input  fba_pkg::cmd_t                  cmd,
	output fba_pkg::dp_stat_t              stat
);
	import fba_pkg::*;

	logic [DATA_W-1:0] first_q, last_q, count_q, floor_q;
	logic [DATA_W-1:0] freem_q, lastm_q, resvm_q;
	logic [DATA_W-1:0] right_q, left_q, cur_q, idx_q, val_q;
	logic [STEP_W-1:0] steps_q;
	logic [ADDR_W-1:0] clr_q;
	logic [DATA_W-1:0] res_blk_q;
	st_code_t          res_st_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] out_blk_q;
	logic [1:0]        out_st_q;
	logic [COUNT_W-1:0] out_cnt_q;

	logic              ld_item;
	logic [ADDR_W-1:0] rd_addr, wr_addr;
	logic [DATA_W-1:0] wr_data, rdata;
	logic [CNT_W-1:0]  steps_x;
	logic [COUNT_W-1:0] freed;

	assign ld_item   = req.valid & cmd.in_ready;
	assign req.ready = cmd.in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 16'd1;
			last_q  <= 16'd2;
			count_q <= 16'd4096;
			floor_q <= 16'd0;
			freem_q <= 16'd0;
			lastm_q <= 16'd65535;
			resvm_q <= 16'd65534;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				R_FIRST: first_q <= cfg_wdata;
				R_LAST:  last_q  <= cfg_wdata;
				R_COUNT: count_q <= cfg_wdata;
				R_FLOOR: floor_q <= cfg_wdata;
				R_FREEM: freem_q <= cfg_wdata;
				R_LASTM: lastm_q <= cfg_wdata;
				R_RESVM: resvm_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// item registers and walk pointers
	always_ff @(posedge clk) begin
		if (ld_item) begin
			right_q <= last_q + 16'd1;
			left_q  <= first_q - 16'd1;
			cur_q   <= req.block_index;
			idx_q   <= req.block_index;
			val_q   <= req.entry_value;
			steps_q <= '0;
		end else begin
			if (cmd.right_inc) begin
				right_q <= right_q + 16'd1;
			end
			if (cmd.left_dec) begin
				left_q <= left_q - 16'd1;
			end
			if (cmd.cur_step) begin
				cur_q   <= rdata;
				steps_q <= steps_q + STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_inc) begin
			clr_q <= clr_q + ADDR_W'(1);
		end
	end

	always_comb begin
		unique case (cmd.rd_sel)
			AS_RIGHT: rd_addr = to_addr(right_q);
			AS_LEFT:  rd_addr = to_addr(left_q);
			AS_CUR:   rd_addr = to_addr(cur_q);
			AS_IDX:   rd_addr = to_addr(idx_q);
			AS_CLR:   rd_addr = clr_q;
			default:  rd_addr = clr_q;
		endcase
		unique case (cmd.wr_sel)
			AS_RIGHT: wr_addr = to_addr(right_q);
			AS_LEFT:  wr_addr = to_addr(left_q);
			AS_CUR:   wr_addr = to_addr(cur_q);
			AS_IDX:   wr_addr = to_addr(idx_q);
			AS_CLR:   wr_addr = clr_q;
			default:  wr_addr = clr_q;
		endcase
		unique case (cmd.wd_sel)
			WD_LAST: wr_data = lastm_q;
			WD_FREE: wr_data = freem_q;
			WD_VAL:  wr_data = val_q;
			WD_ZERO: wr_data = '0;
			default: wr_data = '0;
		endcase
	end

	fba_ram #(
		.W     (DATA_W),
		.DEPTH (MAP_DEPTH)
	) u_link_ram (
		.clk   (clk),
		.we    (cmd.wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (cmd.rd_en),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.res_ld) begin
			unique case (cmd.res_blk)
				BS_ZERO:  res_blk_q <= '0;
				BS_RIGHT: res_blk_q <= right_q;
				BS_LEFT:  res_blk_q <= left_q;
				BS_RDATA: res_blk_q <= rdata;
				default:  res_blk_q <= '0;
			endcase
			res_st_q <= cmd.res_st;
		end
	end

	// saturate the step count into the result field
	assign steps_x = CNT_W'(steps_q);
	assign freed   = (steps_x > CNT_W'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
	                                               : steps_x[COUNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_blk_q <= res_blk_q;
			out_st_q  <= res_st_q;
			out_cnt_q <= freed;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.result_block = out_blk_q;
	assign rsp.status       = out_st_q;
	assign rsp.freed_count  = out_cnt_q;

	always_comb begin
		stat.in_valid   = req.valid;
		stat.in_kind    = kind_t'(req.kind);
		stat.right_ok   = right_q < count_q;
		stat.left_ok    = left_q > floor_q;
		stat.right_in   = in_tbl(right_q);
		stat.left_in    = in_tbl(left_q);
		stat.rdata_free = rdata == freem_q;
		stat.cur_mark   = (cur_q == lastm_q) || (cur_q == resvm_q) || (cur_q == freem_q);
		stat.cur_in     = in_tbl(cur_q);
		stat.step_lim   = steps_q >= STEP_W'(MAP_DEPTH);
		stat.idx_in     = in_tbl(idx_q);
		stat.clr_last   = clr_q == LAST_ADDR;
		stat.out_free   = !out_valid_q || rsp.ready;
	end

endmodule
`default_nettype wire

@@ hw/rtl/fba_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fba_ctrl
// Controller: sequences the table clear, the allocation search, the chain
// walk and the entry accesses.
// ----------------------------------------------------------------------------
module fba_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  fba_pkg::dp_stat_t stat,
	output fba_pkg::cmd_t     cmd
);
	import fba_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = AS_CLR;
				cmd.wd_sel  = WD_ZERO;
				cmd.clr_inc = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (stat.in_valid) begin
					unique case (stat.in_kind)
						K_ALLOC: state_d = S_A_HEAD;
						K_FREE:  state_d = S_F_HEAD;
						K_READ:  state_d = S_RD_CHK;
						K_WRITE: state_d = S_WR_CHK;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_A_HEAD: begin
				if (!stat.left_ok && !stat.right_ok) begin
					cmd.res_ld  = 1'b1;
					cmd.res_blk = BS_ZERO;
					cmd.res_st  = ST_FULL;
					state_d     = S_EMIT;
				end else begin
					state_d = S_A_R;
				end
			end
			S_A_R: begin
				if (stat.right_ok && stat.right_in) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = AS_RIGHT;
					state_d    = S_A_RCMP;
				end else begin
					// candidate past the table counts as taken
					cmd.right_inc = stat.right_ok;
					state_d       = S_A_L;
				end
			end
			S_A_RCMP: begin
				if (stat.rdata_free) begin
					cmd.wr_en   = 1'b1;
					cmd.wr_sel  = AS_RIGHT;
					cmd.wd_sel  = WD_LAST;
					cmd.res_ld  = 1'b1;
					cmd.res_blk = BS_RIGHT;
					cmd.res_st  = ST_OK;
					state_d     = S_EMIT;
				end else begin
					cmd.right_inc = 1'b1;
					state_d       = S_A_L;
				end
			end
			S_A_L: begin
				if (stat.left_ok && stat.left_in) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = AS_LEFT;
					state_d    = S_A_LCMP;
				end else begin
					cmd.left_dec = stat.left_ok;
					state_d      = S_A_HEAD;
				end
			end
			S_A_LCMP: begin
				if (stat.rdata_free) begin
					cmd.wr_en   = 1'b1;
					cmd.wr_sel  = AS_LEFT;
					cmd.wd_sel  = WD_LAST;
					cmd.res_ld  = 1'b1;
					cmd.res_blk = BS_LEFT;
					cmd.res_st  = ST_OK;
					state_d     = S_EMIT;
				end else begin
					cmd.left_dec = 1'b1;
					state_d      = S_A_HEAD;
				end
			end
			S_F_HEAD: begin
				cmd.res_blk = BS_ZERO;
				if (stat.cur_mark) begin
					cmd.res_ld = 1'b1;
					cmd.res_st = ST_OK;
					state_d    = S_EMIT;
				end else if (stat.step_lim) begin
					cmd.res_ld = 1'b1;
					cmd.res_st = ST_LONG;
					state_d    = S_EMIT;
				end else if (!stat.cur_in) begin
					cmd.res_ld = 1'b1;
					cmd.res_st = ST_RANGE;
					state_d    = S_EMIT;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = AS_CUR;
					state_d    = S_F_RD;
				end
			end
			S_F_RD: begin
				cmd.wr_en    = 1'b1;
				cmd.wr_sel   = AS_CUR;
				cmd.wd_sel   = WD_FREE;
				cmd.cur_step = 1'b1;
				state_d      = S_F_HEAD;
			end
			S_RD_CHK: begin
				if (stat.idx_in) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = AS_IDX;
					state_d    = S_RD_WAIT;
				end else begin
					cmd.res_ld  = 1'b1;
					cmd.res_blk = BS_ZERO;
					cmd.res_st  = ST_RANGE;
					state_d     = S_EMIT;
				end
			end
			S_RD_WAIT: begin
				cmd.res_ld  = 1'b1;
				cmd.res_blk = BS_RDATA;
				cmd.res_st  = ST_OK;
				state_d     = S_EMIT;
			end
			S_WR_CHK: begin
				cmd.wr_en   = stat.idx_in;
				cmd.wr_sel  = AS_IDX;
				cmd.wd_sel  = WD_VAL;
				cmd.res_ld  = 1'b1;
				cmd.res_blk = BS_ZERO;
				cmd.res_st  = stat.idx_in ? ST_OK : ST_RANGE;
				state_d     = S_EMIT;
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.in_valid && cmd.in_ready) |=> !cmd.in_ready)
		else $error("second word accepted while an item is in flight");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> stat.out_free)
		else $error("output register overwritten while still held");

	a_cmp_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_A_RCMP || state_q == S_A_LCMP) |-> $past(cmd.rd_en))
		else $error("candidate compared without a table read");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.rd_en && cmd.wr_en))
		else $error("table read and write issued together");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/fat_block_allocator_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fat_block_allocator_unit
// FAT-style block map allocator: allocate, free chain, read and write entry.
// ----------------------------------------------------------------------------
// After reset the unit sweeps all MAP_DEPTH entries of the link table (4096 by
// default) to zero, one entry per clock; req.ready stays low until then,
// while configuration writes are taken at any time. Items are processed one
// at a time and every item yields exactly one response word. The table sits
// in a single RAM with one write and one registered read port, and each
// table read is followed by a decide state that uses the registered data.
// A read entry checks the index and, in range, reads and returns the entry;
// a write entry checks the index and writes; a free chain reads and releases
// each link in turn; an allocation runs search rounds, each a head check,
// then the right side, then the left, where a side reads and compares its
// candidate, or is skipped (out of table or past its limit); a full volume
// ends on a head check. A finished response waits in an output register, so
// the next request word is taken while the previous response is held; a
// response that is still held when the next one is ready stalls the unit
// until it leaves.
// ----------------------------------------------------------------------------
module fat_block_allocator_unit (
	input  wire                           clk,
	input  wire                           arst_n,
	fba_req_if.sink                       req,
	fba_rsp_if.source                     rsp,
	input  wire                           cfg_we,
	input  wire [fba_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [fba_pkg::DATA_W-1:0]     cfg_wdata
);
	import fba_pkg::*;

	// command and status between sequencer and datapath
	cmd_t     cmd;
	dp_stat_t stat;

	// sequencer: clear sweep, radial search, chain walk, entry access
	fba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	// datapath: config registers, pointers, link table, response register
	fba_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule
`default_nettype wire

@@ tb/sv/fat_block_allocator_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fat_block_allocator_unit_tb
// Self-checking bench for the FAT block allocator. A queue of request words
// feeds a driver that idles at random. A scoreboard keeps its own copy of the
// link table and the registers. It predicts each response word as the request
// is taken, and compares responses field by field in order.
// ----------------------------------------------------------------------------
module fat_block_allocator_unit_tb;

	import fba_pkg::*;

	// Nothing is accepted for this long: give up. The slowest word this bench
	// could build is an allocation that scans the whole right side with the
	// widest block count (about 62k rounds), plus the clearing sweep after
	// reset and the longest stalls. This limit is several times that.
	localparam int unsigned STALL_LIMIT = 1000000;

	typedef struct packed {
		kind_t             kind;
		logic [DATA_W-1:0] block_index;
		logic [DATA_W-1:0] entry_value;
	} map_word_t;

	typedef struct packed {
		logic [DATA_W-1:0]  block;
		st_code_t           status;
		logic [COUNT_W-1:0] freed;
	} map_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0] cfg_wdata;

	fba_req_if req_ch ();
	fba_rsp_if rsp_ch ();

	fat_block_allocator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Scoreboard copy of the link table and of the register file.
	logic [DATA_W-1:0] link_shadow [MAP_DEPTH];
	logic [DATA_W-1:0] sh_first, sh_last, sh_count, sh_floor;
	logic [DATA_W-1:0] sh_freem, sh_lastm, sh_resvm;

	map_word_t   pending_words [$];
	map_result_t results_due [$];

	logic word_took = 1'b0;
	logic result_took = 1'b0;
	logic src_quiet = 1'b0;
	logic snk_quiet = 1'b0;
	int unsigned send_gap = 0;
	int unsigned sink_hold = 0;
	int unsigned quiet_cycles = 0;

	int unsigned mismatches = 0;
	int unsigned words_taken = 0;
	int unsigned setups = 1;
	int unsigned granted = 0, full_hits = 0, chains_freed = 0;
	int unsigned long_walks = 0, range_hits = 0;

	// ------------------------------------------------------------------------
	// Scoreboard model: apply one request word to the shadow table and return
	// the response word that the block must produce for it.
	// ------------------------------------------------------------------------
	function automatic map_result_t apply_map_op(input map_word_t w);
		map_result_t r;
		logic [DATA_W-1:0] lp, rp, cur, nxt;
		int unsigned hops;
		bit stop;
		r.block = '0;
		r.status = ST_OK;
		r.freed = '0;
		stop = 1'b0;
		case (w.kind)
			K_ALLOC: begin
				// Both pointers start one step outside the map blocks and wrap as
				// 16-bit counters (first block 0 starts left at 65535, last block
				// 65535 starts right at 0).
				lp = sh_first - 1'b1;
				rp = sh_last + 1'b1;
				r.status = ST_FULL;
				while (!stop && (lp > sh_floor || rp < sh_count)) begin
					// Right goes first; a candidate past the table counts as taken.
					if (rp < sh_count) begin
						if (rp < MAP_DEPTH && link_shadow[rp] == sh_freem) begin
							link_shadow[rp] = sh_lastm;
							r.block = rp;
							r.status = ST_OK;
							stop = 1'b1;
						end else begin
							rp = rp + 1'b1;
						end
					end
					if (!stop && lp > sh_floor) begin
						if (lp < MAP_DEPTH && link_shadow[lp] == sh_freem) begin
							link_shadow[lp] = sh_lastm;
							r.block = lp;
							r.status = ST_OK;
							stop = 1'b1;
						end else begin
							lp = lp - 1'b1;
						end
					end
				end
			end
			K_FREE: begin
				// Walk the chain, releasing each entry, until a mark is reached.
				// A start that is itself a mark frees nothing.
				cur = w.block_index;
				hops = 0;
				while (!stop && cur != sh_lastm && cur != sh_resvm && cur != sh_freem) begin
					if (hops >= MAP_DEPTH) begin
						r.status = ST_LONG;
						stop = 1'b1;
					end else if (cur >= MAP_DEPTH) begin
						// Entries already released stay released.
						r.status = ST_RANGE;
						stop = 1'b1;
					end else begin
						nxt = link_shadow[cur];
						link_shadow[cur] = sh_freem;
						hops++;
						cur = nxt;
					end
				end
				r.freed = COUNT_W'((hops > COUNT_MAX) ? COUNT_MAX : hops);
			end
			K_READ: begin
				if (w.block_index < MAP_DEPTH) begin
					r.block = link_shadow[w.block_index];
				end else begin
					r.status = ST_RANGE;
				end
			end
			default: begin
				if (w.block_index < MAP_DEPTH) begin
					link_shadow[w.block_index] = w.entry_value;
				end else begin
					r.status = ST_RANGE;
				end
			end
		endcase
		return r;
	endfunction

	// Most gaps are zero or short, a few are long; a quiet stretch has none.
	function automatic int unsigned pick_gap(input bit quiet);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 48);
	endfunction

	// Index mostly from the window in play, sometimes anywhere in the table,
	// and sometimes any 16-bit value so that out-of-range words come up too.
	function automatic logic [DATA_W-1:0] pick_index(input int lo, input int hi);
		case ($urandom_range(0, 9))
			0: begin
				return $urandom_range(0, 65535);
			end
			1: begin
				return $urandom_range(0, MAP_DEPTH - 1);
			end
			default: begin
				return $urandom_range(lo, hi);
			end
		endcase
	endfunction

	task automatic push_word(input kind_t k, input logic [DATA_W-1:0] idx,
			input logic [DATA_W-1:0] val);
		map_word_t w;
		w.kind = k;
		w.block_index = idx;
		w.entry_value = val;
		pending_words.push_back(w);
	endtask

	// Hold until every queued word is taken and every response is back.
	task automatic wait_drained();
		while (pending_words.size() != 0 || req_ch.valid || results_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_reg(input cfg_reg_t r, input logic [DATA_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_wdata <= v;
		case (r)
			R_FIRST: sh_first = v;
			R_LAST:  sh_last = v;
			R_COUNT: sh_count = v;
			R_FLOOR: sh_floor = v;
			R_FREEM: sh_freem = v;
			R_LASTM: sh_lastm = v;
			default: sh_resvm = v;
		endcase
	endtask

	// Reprogram all registers, only once the block has gone idle.
	task automatic apply_setup(input logic [DATA_W-1:0] first, last, count, floor_blk,
			freem, lastm, resvm);
		wait_drained();
		repeat (8) @(negedge clk);
		set_reg(R_FIRST, first);
		set_reg(R_LAST, last);
		set_reg(R_COUNT, count);
		set_reg(R_FLOOR, floor_blk);
		set_reg(R_FREEM, freem);
		set_reg(R_LASTM, lastm);
		set_reg(R_RESVM, resvm);
		@(negedge clk);
		cfg_we <= 1'b0;
		setups++;
	endtask

	// ------------------------------------------------------------------------
	// Random traffic. Mostly well-formed chains (write the links, then free
	// from the head) and allocations around the window; the rest is reads,
	// stray writes and frees from arbitrary blocks.
	// ------------------------------------------------------------------------
	task automatic queue_mixed_traffic(input int n, input int lo, input int hi,
			input int alloc_pct);
		int left_items, len, r;
		logic [DATA_W-1:0] links [6];
		logic [DATA_W-1:0] tail;
		left_items = n;
		while (left_items > 0) begin
			r = $urandom_range(0, 99);
			if (r < alloc_pct) begin
				push_word(K_ALLOC, $urandom, $urandom);
				left_items--;
			end else if (r < alloc_pct + 30) begin
				len = $urandom_range(1, 6);
				for (int k = 0; k < len; k++) links[k] = $urandom_range(lo, hi);
				// End the chain on one of the marks, off the table, or anywhere.
				case ($urandom_range(0, 9))
					0: tail = sh_resvm;
					1: tail = sh_freem;
					2: tail = $urandom_range(MAP_DEPTH, 65535);
					3: tail = $urandom;
					default: tail = sh_lastm;
				endcase
				for (int k = 0; k < len; k++)
					push_word(K_WRITE, links[k], (k == len - 1) ? tail : links[k + 1]);
				if ($urandom_range(0, 1) == 1) begin
					push_word(K_READ, links[len - 1], $urandom);
					left_items--;
				end
				if ($urandom_range(0, 3) == 0) begin
					push_word(K_ALLOC, $urandom, $urandom);
					left_items--;
				end
				push_word(K_FREE, links[0], $urandom);
				left_items -= len + 1;
			end else if (r < alloc_pct + 45) begin
				push_word(K_READ, pick_index(lo, hi), $urandom);
				left_items--;
			end else if (r < alloc_pct + 60) begin
				push_word(K_WRITE, pick_index(lo, hi),
					($urandom_range(0, 3) == 0) ? sh_freem : $urandom);
				left_items--;
			end else begin
				push_word(K_FREE, pick_index(lo, hi), $urandom);
				left_items--;
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Request driver: change inputs on the falling edge. Hold a word until it
	// is taken, then idle for the gap picked when the word went out.
	// ------------------------------------------------------------------------
	always @(negedge clk) begin : feed_words
		map_word_t w;
		if ($urandom_range(0, 63) == 0) src_quiet <= !src_quiet;
		if (req_ch.valid && !word_took) begin
			// hold the word until it is taken
		end else if (send_gap != 0) begin
			req_ch.valid <= 1'b0;
			send_gap <= send_gap - 1;
		end else if (pending_words.size() != 0) begin
			w = pending_words.pop_front();
			req_ch.valid <= 1'b1;
			req_ch.kind <= w.kind;
			req_ch.block_index <= w.block_index;
			req_ch.entry_value <= w.entry_value;
			send_gap <= pick_gap(src_quiet);
		end else begin
			req_ch.valid <= 1'b0;
		end
	end

	// Response side: stall after a taken word, and now and then out of the blue,
	// so that ready drops on every phase of the block's work.
	always @(negedge clk) begin : drain_results
		int unsigned g;
		if ($urandom_range(0, 63) == 0) snk_quiet <= !snk_quiet;
		if (sink_hold != 0) begin
			rsp_ch.ready <= 1'b0;
			sink_hold <= sink_hold - 1;
		end else begin
			g = (result_took || $urandom_range(0, 7) == 0) ? pick_gap(snk_quiet) : 0;
			rsp_ch.ready <= (g == 0);
			sink_hold <= (g == 0) ? 0 : g - 1;
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: sample on the rising edge. Check the response first, then
	// predict the taken request word and queue its response.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : watch_ports
		map_word_t w;
		map_result_t want;
		if (arst_n) begin
			word_took <= req_ch.valid && req_ch.ready;
			result_took <= rsp_ch.valid && rsp_ch.ready;
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (results_due.size() == 0) begin
					$error("unexpected response word: result_block %0d status %0d freed_count %0d",
						rsp_ch.result_block, rsp_ch.status, rsp_ch.freed_count);
					mismatches++;
				end else begin
					want = results_due.pop_front();
					if (rsp_ch.result_block !== want.block) begin
						$error("result_block: expected %0d, actual %0d",
							want.block, rsp_ch.result_block);
						mismatches++;
					end
					if (rsp_ch.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
						mismatches++;
					end
					if (rsp_ch.freed_count !== want.freed) begin
						$error("freed_count: expected %0d, actual %0d",
							want.freed, rsp_ch.freed_count);
						mismatches++;
					end
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				w.kind = kind_t'(req_ch.kind);
				w.block_index = req_ch.block_index;
				w.entry_value = req_ch.entry_value;
				want = apply_map_op(w);
				words_taken++;
				if (w.kind == K_ALLOC && want.status == ST_OK) granted++;
				if (want.status == ST_FULL) full_hits++;
				if (w.kind == K_FREE && want.freed != 0) chains_freed++;
				if (want.status == ST_LONG) long_walks++;
				if (want.status == ST_RANGE) range_hits++;
				results_due.push_back(want);
			end
		end
	end

	// Watchdog: count cycles in which neither channel moves a word.
	always @(posedge clk) begin : watchdog
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------
	// Test sequence.
	// ------------------------------------------------------------------------
	initial begin : run_sequence
		int i;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = R_FIRST;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.kind = K_ALLOC;
		req_ch.block_index = '0;
		req_ch.entry_value = '0;
		rsp_ch.ready = 1'b0;
		for (i = 0; i < MAP_DEPTH; i++) link_shadow[i] = '0;
		sh_first = 16'd1;
		sh_last = 16'd2;
		sh_count = 16'd4096;
		sh_floor = 16'd0;
		sh_freem = 16'h0000;
		sh_lastm = 16'hFFFF;
		sh_resvm = 16'hFFFE;

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// Registers at their reset values. Directed words first: table edges,
		// out-of-range reads and writes, chains ending on the reserved and last marks,
		// a start that is a mark, a link that leaves the table.
		push_word(K_READ, 16'd0, 16'h0000);
		push_word(K_READ, 16'd4095, 16'hFFFF);
		push_word(K_READ, 16'd4096, 16'h0000);
		push_word(K_READ, 16'hFFFF, 16'hFFFF);
		push_word(K_WRITE, 16'hFFFF, 16'h1234);
		push_word(K_WRITE, 16'd4096, 16'hAAAA);
		push_word(K_WRITE, 16'd5, 16'h5555);
		push_word(K_READ, 16'd5, 16'h0000);
		push_word(K_ALLOC, 16'h0000, 16'h0000);
		push_word(K_ALLOC, 16'hFFFF, 16'hFFFF);
		push_word(K_ALLOC, 16'h5A5A, 16'hA5A5);
		push_word(K_WRITE, 16'd10, 16'd11);
		push_word(K_WRITE, 16'd11, 16'd12);
		push_word(K_WRITE, 16'd12, 16'hFFFE);
		push_word(K_FREE, 16'd10, 16'h0000);
		push_word(K_FREE, 16'hFFFF, 16'h0000);
		push_word(K_FREE, 16'h0000, 16'h0000);
		push_word(K_FREE, 16'hFFFE, 16'h0000);
		push_word(K_WRITE, 16'd20, 16'd5000);
		push_word(K_FREE, 16'd20, 16'h0000);
		push_word(K_FREE, 16'd4096, 16'h0000);
		push_word(K_FREE, 16'd4, 16'h0000);
		push_word(K_READ, 16'd20, 16'h0000);
		push_word(K_WRITE, 16'd4095, 16'hFFFF);
		queue_mixed_traffic(280, 0, 300, 25);

		// Narrow window so that allocation runs into a full volume.
		apply_setup(16'd100, 16'd120, 16'd200, 16'd50, 16'h0000, 16'hFFFF, 16'hFFFE);
		queue_mixed_traffic(230, 40, 210, 35);

		// Both pointers wrap at the start: right from block 0, left from 65535
		// through skipped out-of-table candidates. Block 0 can be granted.
		apply_setup(16'd0, 16'hFFFF, 16'd16, 16'd65520, 16'h0000, 16'hFFFF, 16'hFFFE);
		for (i = 0; i < 5; i++) push_word(K_ALLOC, $urandom, $urandom);
		queue_mixed_traffic(140, 0, 20, 35);

		// Swap the marks around: zero now ends a chain, all-ones is free.
		apply_setup(16'd2000, 16'd2001, 16'd2100, 16'd1900, 16'hFFFF, 16'h0000, 16'h0001);
		queue_mixed_traffic(190, 1890, 2110, 30);

		// Widest block count; left starts at the table's last entry.
		apply_setup(16'd4096, 16'd3000, 16'hFFFF, 16'd3500, 16'h0000, 16'hFFFF, 16'hFFFE);
		queue_mixed_traffic(240, 2990, 4095, 30);

		// Link the top entries of the table into one chain that runs off its
		// end, so the walk frees them all and then stops out of range. The
		// free mark is moved off zero.
		apply_setup(16'hFFFF, 16'hFFFF, 16'd1, 16'd65533, 16'hF000, 16'hFFFF, 16'hFFFE);
		for (i = MAP_DEPTH - 32; i < MAP_DEPTH; i++)
			push_word(K_WRITE, 16'(i), 16'(i + 1));
		push_word(K_FREE, 16'(MAP_DEPTH - 32), $urandom);
		push_word(K_ALLOC, $urandom, $urandom);
		push_word(K_ALLOC, $urandom, $urandom);
		push_word(K_READ, 16'd4095, $urandom);

		// Empty search range: every allocation reports full at once.
		apply_setup(16'd1, 16'd2, 16'd0, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFE);
		push_word(K_ALLOC, $urandom, $urandom);
		push_word(K_READ, 16'd7, $urandom);
		push_word(K_ALLOC, $urandom, $urandom);

		wait_drained();
		repeat (40) @(posedge clk);
		$display("covered %0d request words over %0d register setups", words_taken, setups);
		$display("%0d blocks granted, %0d full, %0d chains freed, %0d too long, %0d out of range",
			granted, full_hits, chains_freed, long_walks, range_hits);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/fba_pkg.sv
hw/rtl/fba_ifs.sv
hw/rtl/fba_ram.sv
hw/rtl/fba_dpath.sv
hw/rtl/fba_ctrl.sv
hw/rtl/fat_block_allocator_unit.sv
tb/sv/fat_block_allocator_unit_tb.sv
